>>> hdl/list_reorder_move_planner_defines.svh
// ---------------------------------------------------------------------------
// List reorder move planner assertion macros
// Shared macros for the concurrent checks of the planner.
// ---------------------------------------------------------------------------
`ifndef LIST_REORDER_MOVE_PLANNER_DEFINES_SVH
`define LIST_REORDER_MOVE_PLANNER_DEFINES_SVH

// Checks that a property holds at every clock edge outside reset.
`define LRMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define LRMP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lrmp_pkg.sv
// ---------------------------------------------------------------------------
// List reorder move planner package
// Sizes, command codes and the control bundle that drives the list cells.
// ---------------------------------------------------------------------------
package lrmp_pkg;

  localparam int LIST_DEPTH = 256;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = IDX_W + 1;
  localparam int ID_W       = 64;
  localparam int POS_W      = 8;
  localparam int CMD_W      = 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd2;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic append_en;
    logic cmp_en;
    logic apply_en;
    logic found;
    cnt_t count;
    cnt_t place;
  } cell_ctl_t;

endpackage

>>> hdl/lrmp_cell.sv
// ---------------------------------------------------------------------------
// List cell
// Holds one list entry, compares it with the key and takes the entry of its
// lower neighbor when the list shifts.
// ---------------------------------------------------------------------------
module lrmp_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  lrmp_pkg::idx_t    cell_idx,
  input  lrmp_pkg::cell_ctl_t ctl,
  input  lrmp_pkg::id_t     key,
  input  lrmp_pkg::id_t     nbr_entry,
  input  logic              before_in,
  output lrmp_pkg::id_t     entry,
  output logic              match
);

  lrmp_pkg::id_t  entry_r, entry_nxt;
  logic           match_r, match_nxt;
  lrmp_pkg::cnt_t idx_ext;

  assign idx_ext = {1'b0, cell_idx};

  always_comb begin
    entry_nxt = entry_r;
    match_nxt = match_r;
    if (ctl.append_en && idx_ext == ctl.count) begin
      entry_nxt = key;
    end
    if (ctl.cmp_en) begin
      match_nxt = (entry_r == key) && (idx_ext >= ctl.place) && (idx_ext < ctl.count);
    end
    if (ctl.apply_en && ctl.found) begin
      if (idx_ext == ctl.place) begin
        entry_nxt = key;
      end else if (idx_ext > ctl.place && !before_in) begin
        entry_nxt = nbr_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign entry = entry_r;
  assign match = match_r;

endmodule

>>> hdl/lrmp_first.sv
// ---------------------------------------------------------------------------
// First match finder
// Parallel prefix over the cell match flags: marks the cells that lie above
// an earlier match and encodes the position of the first match.
// ---------------------------------------------------------------------------
module lrmp_first (
  input  logic [lrmp_pkg::LIST_DEPTH-1:0] match_vec,
  output logic [lrmp_pkg::LIST_DEPTH-1:0] before_vec,
  output logic                            found,
  output lrmp_pkg::idx_t                  hit_idx
);

  logic [lrmp_pkg::LIST_DEPTH-1:0] lvl [0:lrmp_pkg::IDX_W];
  logic [lrmp_pkg::LIST_DEPTH-1:0] first_vec;

  always_comb begin
    lvl[0] = match_vec;
    for (int k = 0; k < lrmp_pkg::IDX_W; k++) begin
      for (int i = 0; i < lrmp_pkg::LIST_DEPTH; i++) begin
        lvl[k+1][i] = lvl[k][i];
        if (i >= (1 << k)) begin
          lvl[k+1][i] = lvl[k][i] | lvl[k][i - (1 << k)];
        end
      end
    end
  end

  always_comb begin
    before_vec = '0;
    for (int i = 1; i < lrmp_pkg::LIST_DEPTH; i++) begin
      before_vec[i] = lvl[lrmp_pkg::IDX_W][i-1];
    end
  end

  assign first_vec = match_vec & ~before_vec;
  assign found     = |match_vec;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < lrmp_pkg::LIST_DEPTH; i++) begin
      if (first_vec[i]) begin
        hit_idx = hit_idx | lrmp_pkg::IDX_W'(i);
      end
    end
  end

endmodule

>>> hdl/list_reorder_move_planner.sv
// ---------------------------------------------------------------------------
// List reorder move planner
// Keeps a list of identifiers in a row of cells and a place pointer; a place
// item that finds its identifier further on emits one move and rotates it in.
// ---------------------------------------------------------------------------
// Clear and append items are done while idle and the next item follows at once.
// A place item with the pointer below the count steps through accept, compare
// in all cells, then apply the prefix search result and shift the cells; apply
// waits while an earlier move is still held by a stall, and the move is visible in the cycle after apply.
// Synchronous active-low reset empties the list and zeroes the pointer;
// entries themselves are not cleared.
module list_reorder_move_planner (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lrmp_pkg::CMD_W-1:0] in_cmd,
  input  logic [lrmp_pkg::ID_W-1:0]  in_channel_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lrmp_pkg::POS_W-1:0] out_move_from,
  output logic [lrmp_pkg::POS_W-1:0] out_move_to
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]     state_r, state_nxt;
  lrmp_pkg::cnt_t count_r, count_nxt;
  lrmp_pkg::cnt_t place_r, place_nxt;
  lrmp_pkg::id_t  key_r, key_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [lrmp_pkg::POS_W-1:0] from_r, from_nxt, to_r, to_nxt;

  lrmp_pkg::cell_ctl_t ctl;
  lrmp_pkg::id_t       cell_key;
  lrmp_pkg::id_t       ent [0:lrmp_pkg::LIST_DEPTH-1];
  logic [lrmp_pkg::LIST_DEPTH-1:0] match_vec, before_vec;
  logic           found;
  lrmp_pkg::idx_t hit_idx;
  logic           in_acc, emit, fire;
  logic [lrmp_pkg::CNT_W+lrmp_pkg::POS_W-1:0] hit_ext, place_ext;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cell_key  = (state_r == ST_IDLE) ? in_channel_id : key_r;
  assign emit      = found && ({1'b0, hit_idx} != place_r);
  assign fire      = (state_r == ST_APPLY) && (!emit || !out_valid_r || !out_stall);
  assign hit_ext   = {{(lrmp_pkg::POS_W + 1){1'b0}}, hit_idx};
  assign place_ext = {{lrmp_pkg::POS_W{1'b0}}, place_r};

  always_comb begin
    ctl.append_en = in_acc && (in_cmd == lrmp_pkg::CMD_APPEND) &&
                    (count_r < lrmp_pkg::CNT_W'(lrmp_pkg::LIST_DEPTH));
    ctl.cmp_en    = (state_r == ST_CMP);
    ctl.apply_en  = fire;
    ctl.found     = found;
    ctl.count     = count_r;
    ctl.place     = place_r;
  end

  for (genvar g = 0; g < lrmp_pkg::LIST_DEPTH; g++) begin : g_cell
    lrmp_pkg::id_t nbr;
    if (g == 0) begin : g_head
      assign nbr = cell_key;
    end else begin : g_body
      assign nbr = ent[g-1];
    end
    lrmp_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cell_idx  (lrmp_pkg::IDX_W'(g)),
      .ctl       (ctl),
      .key       (cell_key),
      .nbr_entry (nbr),
      .before_in (before_vec[g]),
      .entry     (ent[g]),
      .match     (match_vec[g])
    );
  end

  lrmp_first u_first (
    .match_vec  (match_vec),
    .before_vec (before_vec),
    .found      (found),
    .hit_idx    (hit_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    place_nxt     = place_r;
    key_nxt       = key_r;
    from_nxt      = from_r;
    to_nxt        = to_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            lrmp_pkg::CMD_CLEAR: begin
              count_nxt = '0;
              place_nxt = '0;
            end
            lrmp_pkg::CMD_APPEND: begin
              if (ctl.append_en) begin
                count_nxt = count_r + lrmp_pkg::CNT_W'(1);
              end
            end
            lrmp_pkg::CMD_PLACE: begin
              key_nxt = in_channel_id;
              if (place_r < count_r) begin
                state_nxt = ST_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (fire) begin
          state_nxt = ST_IDLE;
          if (found) begin
            place_nxt = place_r + lrmp_pkg::CNT_W'(1);
          end
          if (emit) begin
            out_valid_nxt = 1'b1;
            from_nxt      = hit_ext[lrmp_pkg::POS_W-1:0];
            to_nxt        = place_ext[lrmp_pkg::POS_W-1:0];
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      place_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      place_r     <= place_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    from_r <= from_nxt;
    to_r   <= to_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_move_from = from_r;
  assign out_move_to   = to_r;

endmodule

>>> hdl/lrmp_checker.sv
// ---------------------------------------------------------------------------
// List reorder move planner checker
// Port-level checks of the result channel and of move timing.
// ---------------------------------------------------------------------------
`include "list_reorder_move_planner_defines.svh"

module lrmp_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [lrmp_pkg::CMD_W-1:0] in_cmd,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [lrmp_pkg::POS_W-1:0] out_move_from,
  input logic [lrmp_pkg::POS_W-1:0] out_move_to
);

  `LRMP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result item dropped while stalled")
  `LRMP_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_move_from) && $stable(out_move_to), "stalled result item changed")
  `LRMP_ASSERT(a_move_order, clk, rst_n, out_valid |-> (out_move_from > out_move_to), "move source not above its target")
  `LRMP_ASSERT(a_move_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && !in_stall && (in_cmd == lrmp_pkg::CMD_PLACE), 3), "move without a place item three cycles earlier")

endmodule

bind list_reorder_move_planner lrmp_checker u_lrmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_cmd        (in_cmd),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_move_from (out_move_from),
  .out_move_to   (out_move_to)
);
